>>> sv/tcw_pkg.sv
// Shared constants, command codes and result type of the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;

	localparam int CURSOR_W  = 15;
	localparam int CHAR_W    = 8;
	localparam int COLOR_W   = 8;
	localparam int CMD_W     = 3;
	localparam int INDEX_W   = 11;
	localparam int CELL_W    = CHAR_W + COLOR_W;

	localparam int COLUMNS_DEF   = 80;
	localparam int ROWS_DEF      = 25;
	localparam int TAB_WIDTH_DEF = 4;

	localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_cell;
		logic [CHAR_W-1:0]   read_char;
		logic [COLOR_W-1:0]  read_color;
		logic                scrolled;
	} res_t;

endpackage
`default_nettype wire

>>> sv/tcw_cmd_if.sv
// Command channel of the text console writer.
`timescale 1ns / 1ps
`default_nettype none
interface tcw_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::CMD_W-1:0]     cmd;
	logic [tcw_pkg::CHAR_W-1:0]    char_code;
	logic [tcw_pkg::COLOR_W-1:0]   color;
	logic [tcw_pkg::CURSOR_W-1:0]  move_count;
	logic [tcw_pkg::INDEX_W-1:0]   read_index;

	modport source (output valid, cmd, char_code, color, move_count, read_index, input ready);
	modport sink (input valid, cmd, char_code, color, move_count, read_index, output ready);
endinterface
`default_nettype wire

>>> sv/tcw_res_if.sv
// Result channel of the text console writer.
`timescale 1ns / 1ps
`default_nettype none
interface tcw_res_if;
	logic                          valid;
	logic                          ready;
	logic [tcw_pkg::CURSOR_W-1:0]  cursor_cell;
	logic [tcw_pkg::CHAR_W-1:0]    read_char;
	logic [tcw_pkg::COLOR_W-1:0]   read_color;
	logic                          scrolled;

	modport source (output valid, cursor_cell, read_char, read_color, scrolled, input ready);
	modport sink (input valid, cursor_cell, read_char, read_color, scrolled, output ready);
endinterface
`default_nettype wire

>>> sv/text_console_writer.sv
// Text console writer top level: sequencer, cell buffer RAM and result register.
// Each command beat gets exactly one result beat. Scrolling walks the cell buffer RAM one cell
// a cycle through its single read and write port. After reset the buffer is zeroed in a pass
// over all cells during which no command is accepted. The result register lets the next
// command in while a result waits on the sink.
`timescale 1ns / 1ps
`default_nettype none
module text_console_writer #(
	parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tcw_cmd_if.sink    command,
	tcw_res_if.source  result
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	tcw_pkg::res_t               res;
	tcw_pkg::res_t               out_q;
	logic                        res_valid;
	logic                        res_ready;
	logic                        ov_q;
	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]  ram_rdata;

	tcw_ctrl #(
		.COLUMNS   (COLUMNS),
		.ROWS      (ROWS),
		.TAB_WIDTH (TAB_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (command),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign res_ready = !ov_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign result.valid       = ov_q;
	assign result.cursor_cell = out_q.cursor_cell;
	assign result.read_char   = out_q.read_char;
	assign result.read_color  = out_q.read_color;
	assign result.scrolled    = out_q.scrolled;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> ov_q)
		else $error("result handed over but output register empty");

endmodule
`default_nettype wire

>>> sv/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> sv/tcw_ctrl.sv
// Command sequencer: cursor, buffer sweeps, row-start arithmetic and cell access.
`timescale 1ns / 1ps
`default_nettype none
module tcw_ctrl #(
	parameter int COLUMNS   = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS      = tcw_pkg::ROWS_DEF,
	parameter int TAB_WIDTH = tcw_pkg::TAB_WIDTH_DEF,
	localparam int CELLS = COLUMNS * ROWS,
	localparam int AW    = $clog2(CELLS)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	tcw_cmd_if.sink                          command,
	output tcw_pkg::res_t                    res,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic                             ram_we,
	output logic [AW-1:0]                    ram_waddr,
	output logic [tcw_pkg::CELL_W-1:0]       ram_wdata,
	output logic                             ram_re,
	output logic [AW-1:0]                    ram_raddr,
	input  wire logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);

	localparam int CW      = tcw_pkg::CURSOR_W;
	localparam int KEEP    = CELLS - COLUMNS;
	localparam int K       = CW + $clog2(COLUMNS);
	localparam int RECIP_W = 17;
	localparam int PW      = CW + RECIP_W;
	localparam int RECIP   = ((1 << K) + COLUMNS - 1) / COLUMNS;
	localparam int TCW     = $clog2(TAB_WIDTH + 1);

	localparam logic [3:0] S_INIT  = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_SCR   = 4'd3;
	localparam logic [3:0] S_SDRN  = 4'd4;
	localparam logic [3:0] S_PRINT = 4'd5;
	localparam logic [3:0] S_DIV1  = 4'd6;
	localparam logic [3:0] S_DIV2  = 4'd7;
	localparam logic [3:0] S_READ  = 4'd8;
	localparam logic [3:0] S_CLR   = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0]                     state_q;
	logic [CW-1:0]                  cur_q;
	logic [AW-1:0]                  ptr_q;
	logic [tcw_pkg::CHAR_W-1:0]     ch_q;
	logic [tcw_pkg::COLOR_W-1:0]    col_q;
	logic [TCW-1:0]                 tab_q;
	logic [PW-1:0]                  prod_q;
	logic [tcw_pkg::CHAR_W-1:0]     rch_q;
	logic [tcw_pkg::COLOR_W-1:0]    rcol_q;
	logic                           scr_q;
	logic                           swv_s1;
	logic [AW-1:0]                  swa_s1;
	logic                           swz_s1;

	logic                           accept;
	logic                           cur_big;
	logic                           idx_ok;
	logic                           ptr_last;
	logic                           ptr_copy;
	logic                           is_tab;
	logic [15:0]                    idx16;
	logic [CW-1:0]                  rowst;

	assign command.ready = (state_q == S_IDLE);
	assign accept        = command.valid && command.ready;
	assign cur_big       = {1'b0, cur_q} >= 16'(CELLS);
	assign idx16         = {5'b0, command.read_index};
	assign idx_ok        = idx16 < 16'(CELLS);
	assign ptr_last      = ptr_q == AW'(CELLS - 1);
	assign ptr_copy      = ptr_q < AW'(KEEP);
	assign is_tab        = ch_q == tcw_pkg::CH_TAB;
	assign rowst         = CW'(prod_q[PW-1:K] * CW'(COLUMNS));

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = ptr_q + AW'(COLUMNS);
		if (swv_s1) begin
			ram_we    = 1'b1;
			ram_waddr = swa_s1;
			ram_wdata = swz_s1 ? '0 : ram_rdata;
		end
		case (state_q)
			S_INIT, S_CLR: begin
				ram_we = 1'b1;
			end
			S_SCR: begin
				ram_re = ptr_copy;
			end
			S_PRINT: begin
				ram_we    = 1'b1;
				ram_waddr = cur_q[AW-1:0];
				ram_wdata = {col_q, is_tab ? tcw_pkg::CH_SPACE : ch_q};
			end
			S_IDLE: begin
				ram_re    = accept && command.cmd == tcw_pkg::CMD_READ && idx_ok;
				ram_raddr = idx16[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			cur_q   <= '0;
			ptr_q   <= '0;
			swv_s1  <= 1'b0;
		end else begin
			swv_s1 <= (state_q == S_SCR);
			case (state_q)
				S_INIT: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (command.cmd)
							tcw_pkg::CMD_PUT: begin
								state_q <= S_CHK;
							end
							tcw_pkg::CMD_LEFT: begin
								cur_q   <= cur_q - command.move_count;
								state_q <= S_DONE;
							end
							tcw_pkg::CMD_RIGHT: begin
								cur_q   <= cur_q + command.move_count;
								state_q <= S_DONE;
							end
							tcw_pkg::CMD_CLEAR: begin
								cur_q   <= '0;
								ptr_q   <= '0;
								state_q <= S_CLR;
							end
							tcw_pkg::CMD_READ: begin
								state_q <= idx_ok ? S_READ : S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_CHK: begin
					if (cur_big) begin
						ptr_q   <= '0;
						state_q <= S_SCR;
					end else if (ch_q == tcw_pkg::CH_NUL) begin
						state_q <= S_DONE;
					end else if (ch_q == tcw_pkg::CH_LF) begin
						cur_q   <= cur_q + CW'(COLUMNS);
						state_q <= S_DIV1;
					end else if (ch_q == tcw_pkg::CH_CR) begin
						state_q <= S_DIV1;
					end else begin
						state_q <= S_PRINT;
					end
				end
				S_SCR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						state_q <= S_SDRN;
					end
				end
				S_SDRN: begin
					cur_q   <= CW'(KEEP);
					state_q <= S_CHK;
				end
				S_PRINT: begin
					cur_q   <= cur_q + 1'b1;
					state_q <= (is_tab && tab_q != '0) ? S_CHK : S_DONE;
				end
				S_DIV1: begin
					state_q <= S_DIV2;
				end
				S_DIV2: begin
					cur_q   <= rowst;
					state_q <= S_DONE;
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_CLR: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		swa_s1 <= ptr_q;
		swz_s1 <= !ptr_copy;
		if (accept) begin
			ch_q   <= command.char_code;
			col_q  <= command.color;
			tab_q  <= TCW'(TAB_WIDTH - 1);
			scr_q  <= 1'b0;
			rch_q  <= '0;
			rcol_q <= '0;
		end
		if (state_q == S_CHK && cur_big) begin
			scr_q <= 1'b1;
		end
		if (state_q == S_PRINT && is_tab && tab_q != '0) begin
			tab_q <= tab_q - 1'b1;
		end
		if (state_q == S_DIV1) begin
			prod_q <= PW'(cur_q) * PW'(RECIP);
		end
		if (state_q == S_READ) begin
			rch_q  <= ram_rdata[tcw_pkg::CHAR_W-1:0];
			rcol_q <= ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
		end
	end

	assign res_valid       = (state_q == S_DONE);
	assign res.cursor_cell = cur_q;
	assign res.read_char   = rch_q;
	assign res.read_color  = rcol_q;
	assign res.scrolled    = scr_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != S_IDLE)
		else $error("command beat accepted but sequencer stayed idle");

	a_print_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PRINT |-> !cur_big)
		else $error("cell write with cursor past screen end");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("buffer read and write hit the same cell");

endmodule
`default_nettype wire

>>> tb/sv/tcw_check_pkg.sv
// Scoreboard for the text console writer: cell buffer and cursor predictor with result checking.
`timescale 1ns / 1ps
package tcw_check_pkg;
	import tcw_pkg::*;

	localparam int SCREEN_CELLS = COLUMNS_DEF * ROWS_DEF;
	localparam int REPORT_MAX   = 10;

	class console_scoreboard;
		logic [CURSOR_W-1:0] cursor_pos;
		logic [CELL_W-1:0]   screen_mem [SCREEN_CELLS];
		res_t                awaited [$];
		int                  failures;

		function new();
			cursor_pos = '0;
			foreach (screen_mem[i]) screen_mem[i] = '0;
			failures = 0;
		endfunction

		function bit scroll_if_past_end();
			if (cursor_pos < SCREEN_CELLS)
				return 1'b0;
			for (int i = 0; i < SCREEN_CELLS - COLUMNS_DEF; i++)
				screen_mem[i] = screen_mem[i + COLUMNS_DEF];
			for (int i = SCREEN_CELLS - COLUMNS_DEF; i < SCREEN_CELLS; i++)
				screen_mem[i] = '0;
			cursor_pos = CURSOR_W'(SCREEN_CELLS - COLUMNS_DEF);
			return 1'b1;
		endfunction

		function void write_glyph(logic [CHAR_W-1:0] ch, logic [COLOR_W-1:0] col);
			if (cursor_pos < SCREEN_CELLS)
				screen_mem[cursor_pos] = {col, ch};
			cursor_pos = cursor_pos + 1'b1;
		endfunction

		function void note_command(logic [CMD_W-1:0] op, logic [CHAR_W-1:0] ch,
				logic [COLOR_W-1:0] col, logic [CURSOR_W-1:0] mv, logic [INDEX_W-1:0] idx);
			res_t r;
			r = '0;
			case (op)
				CMD_PUT: begin
					r.scrolled = scroll_if_past_end();
					case (ch)
						CH_NUL: begin
						end
						CH_LF: begin
							cursor_pos = cursor_pos + CURSOR_W'(COLUMNS_DEF);
							cursor_pos = cursor_pos - CURSOR_W'(cursor_pos % COLUMNS_DEF);
						end
						CH_CR: cursor_pos = cursor_pos - CURSOR_W'(cursor_pos % COLUMNS_DEF);
						CH_TAB: begin
							repeat (TAB_WIDTH_DEF) begin
								if (scroll_if_past_end())
									r.scrolled = 1'b1;
								write_glyph(CH_SPACE, col);
							end
						end
						default: write_glyph(ch, col);
					endcase
				end
				CMD_LEFT: cursor_pos = cursor_pos - mv;
				CMD_RIGHT: cursor_pos = cursor_pos + mv;
				CMD_CLEAR: begin
					foreach (screen_mem[i]) screen_mem[i] = '0;
					cursor_pos = '0;
				end
				CMD_READ: begin
					if (idx < SCREEN_CELLS) begin
						r.read_char  = screen_mem[idx][CHAR_W-1:0];
						r.read_color = screen_mem[idx][CELL_W-1:CHAR_W];
					end
				end
				default: begin
				end
			endcase
			r.cursor_cell = cursor_pos;
			awaited.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected result beat: cursor %0d char %h color %h scrolled %b",
						got.cursor_cell, got.read_char, got.read_color, got.scrolled);
				return;
			end
			want = awaited.pop_front();
			if (got.cursor_cell !== want.cursor_cell || got.read_char !== want.read_char ||
					got.read_color !== want.read_color || got.scrolled !== want.scrolled) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("result mismatch: expected cursor %0d char %h color %h scrolled %b, got cursor %0d char %h color %h scrolled %b",
						want.cursor_cell, want.read_char, want.read_color, want.scrolled,
						got.cursor_cell, got.read_char, got.read_color, got.scrolled);
			end
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		function void close_out();
			if (awaited.size() != 0) begin
				$display("%0d result beats never arrived", awaited.size());
				failures += awaited.size();
			end
		endfunction
	endclass

endpackage

>>> tb/sv/text_console_writer_test.sv
// Randomized handshake test of the text console writer against a scoreboard predictor.
`timescale 1ns / 1ps
module text_console_writer_test;
	import tcw_pkg::*;
	import tcw_check_pkg::*;

	localparam int LIMIT_CYCLES = 4_000_000;
	localparam int TOTAL_ITEMS  = 475;
	localparam int CALM_FROM    = 420;
	localparam int HOLD_AT      = 120;
	localparam int DRAIN_AT     = 300;
	localparam int HOLD_CYCLES  = 400;

	typedef struct packed {
		logic [CMD_W-1:0]    cmd;
		logic [CHAR_W-1:0]   ch;
		logic [COLOR_W-1:0]  col;
		logic [CURSOR_W-1:0] mv;
		logic [INDEX_W-1:0]  idx;
	} cmd_beat_t;

	logic clk;
	logic arst_n;
	int   sent;
	int   cycles;
	bit   calm;
	bit   hold_req;
	console_scoreboard board = new();

	tcw_cmd_if cmd_ch();
	tcw_res_if res_ch();

	text_console_writer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.command(cmd_ch),
		.result(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("** text_console_writer: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && cmd_ch.valid && cmd_ch.ready)
			board.note_command(cmd_ch.cmd, cmd_ch.char_code, cmd_ch.color,
				cmd_ch.move_count, cmd_ch.read_index);
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.cursor_cell = res_ch.cursor_cell;
			got.read_char   = res_ch.read_char;
			got.read_color  = res_ch.read_color;
			got.scrolled    = res_ch.scrolled;
			board.check_result(got);
		end
	end

	initial begin
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				hold_left = $urandom_range(0, 14);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic cmd_beat_t random_beat();
		cmd_beat_t b;
		b.cmd = CMD_W'($urandom_range(0, 7));
		b.ch  = CHAR_W'($urandom_range(0, 255));
		b.col = COLOR_W'($urandom_range(0, 255));
		b.mv  = CURSOR_W'($urandom_range(0, 32767));
		b.idx = INDEX_W'($urandom_range(0, 2047));
		return b;
	endfunction

	// enter at a falling edge, leave at the falling edge after the beat
	task automatic send_beat(input cmd_beat_t b);
		calm = (sent >= CALM_FROM);
		if (!calm && $urandom_range(0, 3) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.cmd        <= b.cmd;
		cmd_ch.char_code  <= b.ch;
		cmd_ch.color      <= b.col;
		cmd_ch.move_count <= b.mv;
		cmd_ch.read_index <= b.idx;
		do @(posedge clk); while (!cmd_ch.ready);
		sent++;
		@(negedge clk);
	endtask

	task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [COLOR_W-1:0] col);
		cmd_beat_t b;
		b = random_beat();
		b.cmd = CMD_PUT;
		b.ch  = ch;
		b.col = col;
		send_beat(b);
	endtask

	task automatic read_at(input int idx);
		cmd_beat_t b;
		b = random_beat();
		b.cmd = CMD_READ;
		b.idx = INDEX_W'(idx);
		send_beat(b);
	endtask

	task automatic move(input logic [CMD_W-1:0] op, input int count);
		cmd_beat_t b;
		b = random_beat();
		b.cmd = op;
		b.mv  = CURSOR_W'(count);
		send_beat(b);
	endtask

	task automatic move_to(input int target);
		if ($urandom_range(0, 1) == 0)
			move(CMD_RIGHT, target - int'(board.cursor_pos));
		else
			move(CMD_LEFT, int'(board.cursor_pos) - target);
	endtask

	task automatic issue(input logic [CMD_W-1:0] op);
		cmd_beat_t b;
		b = random_beat();
		b.cmd = op;
		send_beat(b);
	endtask

	task automatic text_run();
		logic [COLOR_W-1:0] col;
		int len;
		int pick;
		col = COLOR_W'($urandom_range(0, 255));
		len = $urandom_range(3, 25);
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: put_char(CH_LF, col);
				1: put_char(CH_CR, col);
				2: put_char(CH_TAB, col);
				3: put_char(CH_NUL, col);
				4: put_char(CHAR_W'($urandom_range(0, 255)), col);
				default: put_char(CHAR_W'($urandom_range(32, 126)), col);
			endcase
		end
	endtask

	task automatic read_burst();
		int n;
		int back;
		n = $urandom_range(1, 4);
		repeat (n) begin
			back = $urandom_range(0, 40);
			if ($urandom_range(0, 2) != 0 && int'(board.cursor_pos) >= back &&
					board.cursor_pos < SCREEN_CELLS)
				read_at(int'(board.cursor_pos) - back);
			else
				read_at($urandom_range(0, 2047));
		end
	endtask

	initial begin
		int pick;
		bit held;
		bit drained;
		held = 1'b0;
		drained = 1'b0;
		sent = 0;
		cycles = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.cmd = CMD_PUT;
		cmd_ch.char_code = '0;
		cmd_ch.color = '0;
		cmd_ch.move_count = '0;
		cmd_ch.read_index = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		read_at(0);
		put_char(8'd65, 8'hFF);
		put_char(8'hFF, 8'h00);
		put_char(CH_TAB, 8'h5A);
		put_char(CH_CR, 8'h33);
		put_char(CH_LF, 8'hC3);
		put_char(CH_NUL, 8'h12);
		read_at(0);
		read_at(2047);
		move(CMD_LEFT, 1);
		move(CMD_LEFT, 32767);
		move(CMD_RIGHT, 32767);
		issue(CMD_W'(5));
		issue(CMD_W'(7));
		move_to(SCREEN_CELLS - 1);
		put_char(8'd90, 8'h81);
		read_at(SCREEN_CELLS - 1);
		move(CMD_RIGHT, 30000);
		read_at(SCREEN_CELLS - 1);
		put_char(CH_NUL, 8'h00);
		read_at(SCREEN_CELLS - COLUMNS_DEF - 1);
		move_to(SCREEN_CELLS - 2);
		put_char(CH_TAB, 8'hA5);
		issue(CMD_CLEAR);
		read_at(SCREEN_CELLS - COLUMNS_DEF);

		while (sent < TOTAL_ITEMS) begin
			if (!held && sent >= HOLD_AT) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			if (!drained && sent >= DRAIN_AT) begin
				drained = 1'b1;
				cmd_ch.valid <= 1'b0;
				@(negedge clk);
				while (board.outstanding() != 0) @(negedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 45)
				text_run();
			else if (pick < 60)
				move_to($urandom_range(1880, 2005));
			else if (pick < 72)
				read_burst();
			else if (pick < 82)
				move($urandom_range(0, 1) ? CMD_LEFT : CMD_RIGHT,
					$urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom_range(0, 32767));
			else if (pick < 86)
				issue(CMD_W'($urandom_range(5, 7)));
			else if (pick < 88)
				issue(CMD_CLEAR);
			else
				put_char(CHAR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));
		end

		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (board.outstanding() != 0) @(negedge clk);
		repeat (64) @(negedge clk);
		board.close_out();
		if (board.failures == 0)
			$display("** text_console_writer: PASSED **");
		else
			$display("** text_console_writer: FAILED **");
		$finish;
	end

endmodule

>>> files.f
sv/tcw_pkg.sv
sv/tcw_cmd_if.sv
sv/tcw_res_if.sv
sv/tcw_ram.sv
sv/tcw_ctrl.sv
sv/text_console_writer.sv
tb/sv/tcw_check_pkg.sv
tb/sv/text_console_writer_test.sv
